// ===== rtl/tls_pkg.sv =====
package tls_pkg;
   localparam int NORM_WIDTH = 16;
   localparam int COLOR_WIDTH = 24;
   localparam int VEC_WIDTH = 48;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 48;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIGHT_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIGHT_COLOR = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIGHT_POSITION = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIGHT_DIRECTION = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROLLOFF = 3'd4;
   localparam logic [1:0] MODE_POINT = 2'd0;
   localparam logic [1:0] MODE_DIRECTIONAL = 2'd1;
   localparam logic [1:0] MODE_AMBIENT = 2'd2;
   localparam logic [16:0] FACTOR_ONE = 17'd65536;
   localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
endpackage

// ===== rtl/tls_req_if.sv =====
interface tls_req_if;
   logic valid;
   logic ready;
   logic [47:0] vertex_a;
   logic [47:0] vertex_b;
   logic [47:0] vertex_c;
   logic [47:0] face_normal;
   logic [23:0] surface_color;
   logic [23:0] shade_in;
   modport source (output valid, vertex_a, vertex_b, vertex_c, face_normal, surface_color,
      shade_in, input ready);
   modport sink (input valid, vertex_a, vertex_b, vertex_c, face_normal, surface_color,
      shade_in, output ready);
endinterface

// ===== rtl/tls_rsp_if.sv =====
interface tls_rsp_if;
   logic valid;
   logic ready;
   logic [23:0] shade_out;
   logic contributed;
   modport source (output valid, shade_out, contributed, input ready);
   modport sink (input valid, shade_out, contributed, output ready);
endinterface

// ===== rtl/triangle_light_shader_unit.sv =====
// Six register stages lie between request transfer and response valid.
// Throughput: one triangle per cycle; a stalled response holds the whole pipeline.
// Stages: sums, products, dot/square sums, factor mult, factor, blend.
// Reset (synchronous, active high) clears valid bits and loads register defaults.
module triangle_light_shader_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   tls_req_if.sink req,
   tls_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic [tls_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tls_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import tls_pkg::*;

   localparam int XW = 3 * COORD_WIDTH;           // three packed components
   localparam int SW = COORD_WIDTH + 3;           // centroid sum width
   localparam int PW = SW + NORM_WIDTH;           // normal*sum product
   localparam int QW = 2 * SW;                    // square
   localparam int S2W = QW + 2;
   localparam int S2X = S2W > 41 ? S2W : 41;
   localparam int DW = PW + 2;
   localparam int RW = 41 + 16;                   // clipped s2 * rolloff
   localparam int DIV9_LIMIT = 589815;            // 9 * 65535
   localparam logic [19:0] RECIP9 = 20'd932068;   // ceil(2^23 / 9)

   logic [1:0] mode_ff;
   logic [23:0] color_ff;
   logic [47:0] pos_ff, dir_ff;
   logic [15:0] rolloff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_AMBIENT;
         color_ff <= 24'hCCCCCC;
         pos_ff <= '0;
         dir_ff <= '0;
         rolloff_ff <= 16'd256;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LIGHT_MODE: mode_ff <= csr_write_data[1:0];
            REG_LIGHT_COLOR: color_ff <= csr_write_data[23:0];
            REG_LIGHT_POSITION: pos_ff <= csr_write_data;
            REG_LIGHT_DIRECTION: dir_ff <= csr_write_data;
            REG_ROLLOFF: rolloff_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   logic advance;
   logic [5:0] valid_ff;
   assign advance = !valid_ff[5] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[4:0], req.valid};
   end

   // widen or trim the packed vectors; components past bit 47 read as 0
   logic [XW-1:0] va_x, vb_x, vc_x, pos_x;
   assign va_x = XW'(req.vertex_a);
   assign vb_x = XW'(req.vertex_b);
   assign vc_x = XW'(req.vertex_c);
   assign pos_x = XW'(pos_ff);

   // stage 1: centroid offsets
   logic signed [SW-1:0] s_ff [3];
   logic signed [NORM_WIDTH-1:0] n1_ff [3];
   logic [23:0] surf1_ff, shade1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= SW'(signed'(va_x[i*COORD_WIDTH +: COORD_WIDTH]))
               + SW'(signed'(vb_x[i*COORD_WIDTH +: COORD_WIDTH]))
               + SW'(signed'(vc_x[i*COORD_WIDTH +: COORD_WIDTH]))
               - SW'(signed'(pos_x[i*COORD_WIDTH +: COORD_WIDTH])) * SW'(3);
            n1_ff[i] <= req.face_normal[i*NORM_WIDTH +: NORM_WIDTH];
         end
         surf1_ff <= req.surface_color;
         shade1_ff <= req.shade_in;
      end
   end

   // stage 2: products
   logic signed [PW-1:0] np_ff [3];
   logic [QW-1:0] sq_ff [3];
   logic signed [31:0] dp_ff [3];
   logic [23:0] surf2_ff, shade2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            np_ff[i] <= PW'(n1_ff[i]) * PW'(s_ff[i]);
            sq_ff[i] <= QW'(QW'(s_ff[i]) * QW'(s_ff[i]));
            dp_ff[i] <= 32'(n1_ff[i]) * 32'(signed'(dir_ff[i*NORM_WIDTH +: NORM_WIDTH]));
         end
         surf2_ff <= surf1_ff;
         shade2_ff <= shade1_ff;
      end
   end

   // stage 3: sums
   logic signed [DW-1:0] dot_ff;
   logic [S2W-1:0] s2_ff;
   logic signed [33:0] dd_ff;
   logic [23:0] surf3_ff, shade3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dot_ff <= DW'(np_ff[0]) + DW'(np_ff[1]) + DW'(np_ff[2]);
         s2_ff <= S2W'(sq_ff[0]) + S2W'(sq_ff[1]) + S2W'(sq_ff[2]);
         dd_ff <= 34'(dp_ff[0]) + 34'(dp_ff[1]) + 34'(dp_ff[2]);
         surf3_ff <= surf2_ff;
         shade3_ff <= shade2_ff;
      end
   end

   // stage 4: s2*rolloff and directional factor
   logic [RW-1:0] prod_ff;
   logic big_ff, rzero_ff, cull_ff, dneg_ff;
   logic [16:0] dfac_ff;
   logic [23:0] surf4_ff, shade4_ff;
   logic [33:0] negd;
   logic [S2X-1:0] s2_x;
   assign negd = -dd_ff;
   assign s2_x = S2X'(s2_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= RW'(s2_x[40:0]) * RW'(rolloff_ff);
         big_ff <= (s2_x >> 40) != '0;
         rzero_ff <= rolloff_ff == '0;
         cull_ff <= dot_ff > 0;
         dneg_ff <= dd_ff < 0;
         dfac_ff <= (negd[33:12] > 22'(FACTOR_ONE)) ? FACTOR_ONE : negd[28:12];
         surf4_ff <= surf3_ff;
         shade4_ff <= shade3_ff;
      end
   end

   // stage 5: ceil(prod/2304) as ceil(ceil(prod/256) / 9), factor select
   logic [RW-9:0] t;
   logic t_big;
   logic [19:0] u;
   logic [39:0] qm;
   logic [16:0] pfac;
   logic [23:0] c1;
   assign t = prod_ff[RW-1:8] + (RW-8)'(prod_ff[7:0] != '0);
   // past this bound the quotient reaches 65536 and the factor floors at zero
   assign t_big = t > (RW-8)'(DIV9_LIMIT);
   assign u = t[19:0] + 20'd8;
   // floor(u / 9) by reciprocal, exact for u below 2^21
   assign qm = 40'(u) * 40'(RECIP9);
   always_comb begin
      if (big_ff) pfac = rzero_ff ? FACTOR_ONE : '0;
      else if (t_big) pfac = '0;
      else pfac = FACTOR_ONE - qm[39:23];
   end
   assign c1 = (mode_ff == MODE_DIRECTIONAL) ? COLOR_WHITE : surf4_ff;

   logic [16:0] f_ff;
   logic [15:0] ab_ff [3];
   logic [23:0] shade5_ff;
   logic hit_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         shade5_ff <= shade4_ff;
         for (int c = 0; c < 3; c++) begin
            ab_ff[c] <= 16'(c1[c*8 +: 8]) * 16'(color_ff[c*8 +: 8]);
         end
         case (mode_ff)
            MODE_POINT: begin
               f_ff <= pfac; hit_ff <= !cull_ff;
            end
            MODE_DIRECTIONAL: begin
               f_ff <= dfac_ff; hit_ff <= dneg_ff;
            end
            MODE_AMBIENT: begin
               f_ff <= FACTOR_ONE; hit_ff <= 1'b1;
            end
            default: begin
               f_ff <= '0; hit_ff <= 1'b0;
            end
         endcase
      end
   end

   // stage 6: blend
   logic [23:0] out_ff;
   logic hit6_ff;
   logic [23:0] blended;
   always_comb begin
      logic [32:0] abf;
      logic [9:0] r;
      for (int c = 0; c < 3; c++) begin
         abf = 33'(ab_ff[c]) * 33'(f_ff);
         r = 10'(shade5_ff[c*8 +: 8]) + 10'(abf[32:24]);
         blended[c*8 +: 8] = (r > 10'd255) ? 8'd255 : r[7:0];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= hit_ff ? blended : shade5_ff;
         hit6_ff <= hit_ff;
      end
   end

   assign rsp.valid = valid_ff[5];
   assign rsp.shade_out = out_ff;
   assign rsp.contributed = hit6_ff;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import tls_pkg::*;

   localparam int CW = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NONE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   tls_req_if req ();
   tls_rsp_if rsp ();

   triangle_light_shader_unit #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   typedef struct packed {
      logic [23:0] shade;
      logic hit;
   } shade_type;

   // shadow copy of the light registers
   logic [1:0] sh_mode;
   logic [23:0] sh_color;
   logic [47:0] sh_pos;
   logic [47:0] sh_dir;
   logic [15:0] sh_rolloff;

   shade_type shade_queue[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint signed coord(logic [47:0] v, int idx);
      logic [CW-1:0] u;
      u = v[idx*CW +: CW];
      return longint'(signed'(u));
   endfunction

   function automatic longint signed norm(logic [47:0] v, int idx);
      logic signed [15:0] u;
      u = v[idx*16 +: 16];
      return longint'(u);
   endfunction

   function automatic logic [23:0] mix_light(logic [23:0] c1, logic [23:0] c2,
                                             longint unsigned f, logic [23:0] acc);
      logic [23:0] o;
      longint unsigned r;
      for (int ch = 0; ch < 3; ch++) begin
         r = longint'(acc[ch*8 +: 8]) +
             ((longint'(c1[ch*8 +: 8]) * longint'(c2[ch*8 +: 8]) * f) >> 24);
         if (r > 255) r = 255;
         o[ch*8 +: 8] = r[7:0];
      end
      return o;
   endfunction

   function automatic shade_type shade_triangle(logic [47:0] va, logic [47:0] vb,
      logic [47:0] vc, logic [47:0] nrm, logic [23:0] surf, logic [23:0] acc);
      shade_type res;
      longint signed s, dotp, d;
      longint unsigned s2, q, f;
      res.shade = acc;
      res.hit = 1'b0;
      dotp = 0;
      s2 = 0;
      d = 0;
      case (sh_mode)
         MODE_POINT: begin
            for (int i = 0; i < 3; i++) begin
               s = coord(va, i) + coord(vb, i) + coord(vc, i) - 3 * coord(sh_pos, i);
               dotp += norm(nrm, i) * s;
               s2 += longint'(s * s);
            end
            if (dotp <= 0) begin
               if (s2 >= 64'd1 << 40) f = (sh_rolloff == 0) ? 65536 : 0;
               else begin
                  q = (s2 * sh_rolloff + 2303) / 2304;
                  f = (q >= 65536) ? 0 : 65536 - q;
               end
               res.shade = mix_light(surf, sh_color, f, acc);
               res.hit = 1'b1;
            end
         end
         MODE_DIRECTIONAL: begin
            for (int i = 0; i < 3; i++) d += norm(sh_dir, i) * norm(nrm, i);
            if (d < 0) begin
               f = longint'(-d) >> 12;
               if (f > 65536) f = 65536;
               res.shade = mix_light(COLOR_WHITE, sh_color, f, acc);
               res.hit = 1'b1;
            end
         end
         MODE_AMBIENT: begin
            res.shade = mix_light(surf, sh_color, 65536, acc);
            res.hit = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   initial begin
      req.valid = 1'b0;
      req.vertex_a = '0;
      req.vertex_b = '0;
      req.vertex_c = '0;
      req.face_normal = '0;
      req.surface_color = '0;
      req.shade_in = '0;
      rsp.ready = 1'b0;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check each response transfer
   always @(posedge clock) begin
      shade_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (shade_queue.size() == 0) begin
            $error("unexpected response shade_out=%h", rsp.shade_out);
            errors++;
         end else begin
            want = shade_queue.pop_front();
            if (rsp.shade_out !== want.shade) begin
               $error("shade_out expected %h actual %h", want.shade, rsp.shade_out);
               errors++;
            end
            if (rsp.contributed !== want.hit) begin
               $error("contributed expected %b actual %b", want.hit, rsp.contributed);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_triangle(logic [47:0] va, logic [47:0] vb, logic [47:0] vc,
                                logic [47:0] nrm, logic [23:0] surf, logic [23:0] acc);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.vertex_a <= va;
      req.vertex_b <= vb;
      req.vertex_c <= vc;
      req.face_normal <= nrm;
      req.surface_color <= surf;
      req.shade_in <= acc;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      shade_queue.push_back(shade_triangle(va, vb, vc, nrm, surf, acc));
      // drop valid right after the transfer edge
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      while (shade_queue.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [47:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_LIGHT_MODE: sh_mode = value[1:0];
         REG_LIGHT_COLOR: sh_color = value[23:0];
         REG_LIGHT_POSITION: sh_pos = value;
         REG_LIGHT_DIRECTION: sh_dir = value;
         REG_ROLLOFF: sh_rolloff = value[15:0];
         default: ;
      endcase
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(16'hFFFF)), $urandom()};
   endfunction

   // small coordinates keep point lights off the zero floor
   function automatic logic [47:0] near_vec();
      logic [47:0] v;
      for (int i = 0; i < 3; i++) v[i*16 +: 16] = 16'($signed($urandom_range(1024)) - 512);
      return v;
   endfunction

   function automatic logic [47:0] unit_vec();
      logic [47:0] v;
      for (int i = 0; i < 3; i++) v[i*16 +: 16] = 16'($signed($urandom_range(32768)) - 16384);
      return v;
   endfunction

   task automatic random_triangle();
      int k;
      k = $urandom_range(3);
      if (k == 0)
         send_triangle(rand48(), rand48(), rand48(), rand48(), 24'($urandom()),
                       24'($urandom()));
      else
         send_triangle(near_vec(), near_vec(), near_vec(), unit_vec(), 24'($urandom()),
                       24'($urandom()));
   endtask

   task automatic test_reset_ambient();
      send_triangle('0, '0, '0, '0, 24'hFFFFFF, 24'h000000);
      send_triangle('1, '1, '1, '1, 24'hFFFFFF, 24'hFFFFFF);
      send_triangle(rand48(), rand48(), rand48(), rand48(), 24'h808080, 24'h102030);
      drain_pipe();
   endtask

   task automatic test_point_directed();
      write_reg(REG_LIGHT_MODE, 48'(MODE_POINT));
      write_reg(REG_LIGHT_COLOR, 48'hFFFFFF);
      write_reg(REG_LIGHT_POSITION, 48'h0100_0100_0100);
      write_reg(REG_ROLLOFF, 48'd256);
      // centroid on the light: full weight
      send_triangle(48'h0100_0100_0100, 48'h0100_0100_0100, 48'h0100_0100_0100,
                    48'h4000_0000_0000, 24'hFFFFFF, 24'h000000);
      // normal facing away: culled
      send_triangle('0, '0, 48'h0000_0000_0400, 48'h0000_0000_4000, 24'h80FF40, 24'h010203);
      // far away: factor floored to zero
      send_triangle(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                    48'h8000_8000_8000, 24'hFFFFFF, 24'h112233);
      send_triangle(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                    48'h7FFF_7FFF_7FFF, 24'hFFFFFF, 24'hFFFFFF);
      drain_pipe();
      write_reg(REG_ROLLOFF, 48'd0);
      write_reg(REG_LIGHT_POSITION, 48'h8000_7FFF_8000);
      send_triangle(48'h7FFF_8000_7FFF, 48'h7FFF_8000_7FFF, 48'h7FFF_8000_7FFF,
                    '0, 24'hFFFFFF, 24'h00FF00);
      drain_pipe();
      write_reg(REG_ROLLOFF, 48'hFFFF);
      send_triangle(48'h0101_0100_0100, 48'h0100_0100_0100, 48'h0100_0100_0100,
                    '0, 24'hFFFFFF, 24'h000000);
      drain_pipe();
   endtask

   task automatic test_directional_directed();
      write_reg(REG_LIGHT_MODE, 48'(MODE_DIRECTIONAL));
      write_reg(REG_LIGHT_COLOR, 48'hCC8844);
      write_reg(REG_LIGHT_DIRECTION, 48'h0000_0000_C000);
      send_triangle('0, '0, '0, 48'h0000_0000_4000, 24'h0, 24'h000000);  // facing light
      send_triangle('0, '0, '0, 48'h0000_0000_C000, 24'h0, 24'h123456);  // facing away
      send_triangle('0, '0, '0, 48'h0000_4000_0000, 24'h0, 24'h654321);  // edge-on
      drain_pipe();
      // unnormalized axis saturates the factor
      write_reg(REG_LIGHT_DIRECTION, 48'h8000_8000_8000);
      send_triangle('0, '0, '0, 48'h7FFF_7FFF_7FFF, 24'h0, 24'hF0F0F0);
      send_triangle('0, '0, '0, 48'h0001_0000_0000, 24'h0, 24'h000000);
      drain_pipe();
      // unused mode: no light
      write_reg(REG_LIGHT_MODE, 48'(MODE_NONE));
      send_triangle(rand48(), rand48(), rand48(), rand48(), 24'hFFFFFF, 24'hABCDEF);
      drain_pipe();
      // out-of-range index is ignored
      write_reg(REG_NONE, 48'hFFFF_FFFF_FFFF);
      send_triangle(rand48(), rand48(), rand48(), rand48(), 24'hFFFFFF, 24'h000000);
      drain_pipe();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) begin
            drain_pipe();
            write_reg(REG_LIGHT_MODE, ($urandom_range(15) == 0) ? 48'(MODE_NONE)
                                                                : 48'($urandom_range(2)));
            write_reg(REG_LIGHT_COLOR, ($urandom_range(3) == 0) ? 48'hFFFFFF
                                                                : 48'($urandom()));
            write_reg(REG_LIGHT_POSITION, ($urandom_range(3) == 0) ? rand48() : near_vec());
            write_reg(REG_LIGHT_DIRECTION, ($urandom_range(3) == 0) ? rand48() : unit_vec());
            write_reg(REG_ROLLOFF, ($urandom_range(3) == 0) ? 48'($urandom_range(16'hFFFF))
                                                            : 48'($urandom_range(64)));
         end
         random_triangle();
      end
      drain_pipe();
   endtask

   initial begin
      sh_mode = MODE_AMBIENT;
      sh_color = 24'hCCCCCC;
      sh_pos = '0;
      sh_dir = '0;
      sh_rolloff = 16'd256;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 60;
      test_reset_ambient();
      test_point_directed();
      test_directional_directed();
      test_random(560);
      send_idle_pct = 60;
      recv_idle_pct = 19;
      test_random(560);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(560);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
